/* sv/fssd_pkg.sv */
// Shared types, codes and font table for the fourteen-segment LED strip digit.
`default_nettype none

package fssd_pkg;

    localparam int SEG_COUNT = 14;

    typedef enum logic [2:0] {
        MODE_SET_SEG  = 3'd0,
        MODE_SET_MASK = 3'd1,
        MODE_SET_CHAR = 3'd2,
        MODE_ERASE    = 3'd3,
        MODE_FILL     = 3'd4,
        MODE_READ     = 3'd5
    } mode_t;

    localparam logic [3:0] SEG_A     = 4'd0;
    localparam logic [3:0] SEG_B     = 4'd1;
    localparam logic [3:0] SEG_C     = 4'd2;
    localparam logic [3:0] SEG_D     = 4'd3;
    localparam logic [3:0] SEG_E     = 4'd4;
    localparam logic [3:0] SEG_F     = 4'd5;
    localparam logic [3:0] SEG_G     = 4'd6;
    localparam logic [3:0] SEG_H     = 4'd7;
    localparam logic [3:0] SEG_I     = 4'd8;
    localparam logic [3:0] SEG_J     = 4'd9;
    localparam logic [3:0] SEG_K     = 4'd10;
    localparam logic [3:0] SEG_L     = 4'd11;
    localparam logic [3:0] SEG_M     = 4'd12;
    localparam logic [3:0] SEG_N     = 4'd13;
    localparam logic [3:0] OWNER_GAP = 4'd14;

    localparam logic [5:0] LONG_MAX  = 6'd40;
    localparam logic [3:0] SHORT_MAX = 4'd10;

    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_LAST  = 8'd126;

    localparam logic [1:0] CFG_LONG  = 2'd0;
    localparam logic [1:0] CFG_SHORT = 2'd1;
    localparam logic [1:0] CFG_GAP   = 2'd2;

    localparam int FONT_DEPTH = 95;

    localparam logic [13:0] FONT_ROM [0:FONT_DEPTH-1] = '{
        14'h0000, 14'h0208, 14'h0202, 14'h134E, 14'h136D, 14'h2424, 14'h0CD9, 14'h0200,
        14'h0039, 14'h000F, 14'h3FC0, 14'h12C0, 14'h2000, 14'h0040, 14'h0000, 14'h2400,
        14'h003F, 14'h0406, 14'h00DB, 14'h008F, 14'h00E6, 14'h00ED, 14'h00FD, 14'h1401,
        14'h00FF, 14'h00E7, 14'h0000, 14'h2200, 14'h0C00, 14'h00C8, 14'h2100, 14'h1083,
        14'h033B, 14'h00F7, 14'h128F, 14'h0039, 14'h120F, 14'h00F9, 14'h00F1, 14'h00BD,
        14'h00F6, 14'h1209, 14'h001E, 14'h0C70, 14'h0038, 14'h0536, 14'h0936, 14'h003F,
        14'h00F3, 14'h083F, 14'h08F3, 14'h018D, 14'h1201, 14'h003E, 14'h2430, 14'h2836,
        14'h2D00, 14'h1500, 14'h2409, 14'h0039, 14'h0880, 14'h000F, 14'h2800, 14'h0008,
        14'h0080, 14'h00DF, 14'h0878, 14'h00D8, 14'h208E, 14'h0079, 14'h0071, 14'h018F,
        14'h00F4, 14'h1000, 14'h000E, 14'h1E00, 14'h1200, 14'h10D4, 14'h0850, 14'h00DC,
        14'h0471, 14'h08E3, 14'h0050, 14'h018D, 14'h0078, 14'h001C, 14'h2010, 14'h2814,
        14'h2D00, 14'h028E, 14'h2409, 14'h20C9, 14'h1200, 14'h0D09, 14'h0152
    };

    function automatic logic [13:0] font_lookup(input logic [6:0] idx);
        logic [13:0] bits;
        bits = 14'd0;
        if (int'(idx) < FONT_DEPTH) begin
            bits = FONT_ROM[idx];
        end
        return bits;
    endfunction

    typedef struct packed {
        mode_t        mode;
        logic [3:0]   segment_index;
        logic [13:0]  segment_bits;
        logic [7:0]   char_code;
        logic [23:0]  color;
        logic [7:0]   pixel_index;
    } cmd_t;

    typedef struct packed {
        logic [3:0] owner;
        logic       hit;
        logic [7:0] total;
    } map_t;

endpackage

`default_nettype wire

/* sv/fourteen_segment_led_strip_digit.sv */
// Top level: request register, color store, pixel map and result register.
// A request is held in the input register, then its result in the result register, on m_.
// Throughput: one request per cycle unless m_tready stalls the result register; a full input register then waits.
// The command update and the pixel lookup both happen between the input and result registers.
// Reset (aresetn low, synchronous): both stages empty, all colors dark,
// long_count 3, short_count 2, gap_count 0.
`default_nettype none

module fourteen_segment_led_strip_digit #(
    parameter int FONT_ENTRIES = 96
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // segment_index[3:0], segment_bits[17:4], char_code[25:18], red[33:26],
    // green[41:34], blue[49:42], pixel_index[57:50], zero fill [63:58]
    input  wire logic [63:0] s_tdata,
    // mode[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_owner[27:24],
    // total_leds[35:28], zero fill [39:36]
    output logic      [39:0] m_tdata,
    // index_valid[0], set only for a read whose pixel index lies inside the strip
    output logic      [0:0]  m_tuser
);
    import fssd_pkg::*;

    logic [5:0]  long_count_reg;
    logic [3:0]  short_count_reg;
    logic [3:0]  gap_count_reg;

    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic        out_valid_reg;
    logic [23:0] out_color_reg;
    logic [3:0]  out_owner_reg;
    logic        out_hit_reg;
    logic [7:0]  out_total_reg;

    logic        advance;
    logic        exec_en;
    logic        is_read;
    map_t        map;
    logic [23:0] read_color;
    cmd_t        s_cmd;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign exec_en  = in_valid_reg && advance;
    assign is_read  = (in_cmd_reg.mode == MODE_READ) && map.hit;

    assign s_cmd.mode          = mode_t'(s_tuser);
    assign s_cmd.segment_index = s_tdata[3:0];
    assign s_cmd.segment_bits  = s_tdata[17:4];
    assign s_cmd.char_code     = s_tdata[25:18];
    assign s_cmd.color         = {s_tdata[33:26], s_tdata[41:34], s_tdata[49:42]};
    assign s_cmd.pixel_index   = s_tdata[57:50];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_count_reg  <= 6'd3;
            short_count_reg <= 4'd2;
            gap_count_reg   <= 4'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LONG:  long_count_reg  <= cfg_wdata;
                CFG_SHORT: short_count_reg <= cfg_wdata[3:0];
                CFG_GAP:   gap_count_reg   <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    fssd_pixel_map u_map (
        .long_count  (long_count_reg),
        .short_count (short_count_reg),
        .gap_count   (gap_count_reg),
        .pixel_index (in_cmd_reg.pixel_index),
        .map         (map)
    );

    fssd_color_store #(
        .FONT_ENTRIES (FONT_ENTRIES)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .exec_en    (exec_en),
        .cmd        (in_cmd_reg),
        .read_owner (map.owner),
        .read_color (read_color)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_cmd;
        end
        if (exec_en) begin
            out_color_reg <= is_read ? read_color : 24'd0;
            out_owner_reg <= is_read ? map.owner : SEG_A;
            out_hit_reg   <= is_read;
            out_total_reg <= map.total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_total_reg, out_owner_reg,
                       out_color_reg[7:0], out_color_reg[15:8], out_color_reg[23:16]};
    assign m_tuser  = out_hit_reg;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline not empty after reset");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_hit_reg) |-> (out_owner_reg == SEG_A && out_color_reg == 24'd0))
        else $error("non-read or miss result carries pixel data");

    a_owner_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_hit_reg) |-> (out_owner_reg <= OWNER_GAP))
        else $error("owner code out of range");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || m_tready) |-> s_tready)
        else $error("input stalled while result side is free");

endmodule

`default_nettype wire

/* sv/fssd_pixel_map.sv */
// Strip pixel index to owning segment, from the effective LED counts.
`default_nettype none

module fssd_pixel_map (
    input  wire logic [5:0]    long_count,
    input  wire logic [3:0]    short_count,
    input  wire logic [3:0]    gap_count,
    input  wire logic [7:0]    pixel_index,
    output fssd_pkg::map_t     map
);
    import fssd_pkg::*;

    logic [5:0] lc;
    logic [3:0] sc;
    logic [3:0] gc;
    logic [7:0] l8;
    logic [7:0] s8;
    logic [7:0] g8;
    logic [7:0] half;
    logic [7:0] base;
    logic [7:0] total;

    assign lc    = (long_count > LONG_MAX) ? LONG_MAX : long_count;
    assign sc    = (short_count > SHORT_MAX) ? SHORT_MAX : short_count;
    assign gc    = (gap_count > sc) ? sc : gap_count;
    assign l8    = {2'b00, lc};
    assign s8    = {4'b0000, sc};
    assign g8    = {4'b0000, gc};
    assign half  = (s8 - g8) >> 1;
    assign base  = (l8 << 2) + (s8 << 3);
    assign total = base + s8;

    always_comb begin
        map.total = total;
        map.hit   = (pixel_index < total);
        priority if (!map.hit) begin
            map.owner = SEG_A;
        end else if (pixel_index < l8) begin
            map.owner = SEG_I;
        end else if (pixel_index < (l8 << 1)) begin
            map.owner = SEG_K;
        end else if (pixel_index < (l8 << 1) + s8) begin
            map.owner = SEG_B;
        end else if (pixel_index < (l8 << 1) + (s8 << 1)) begin
            map.owner = SEG_C;
        end else if (pixel_index < (l8 << 1) + l8 + (s8 << 1)) begin
            map.owner = SEG_L;
        end else if (pixel_index < (l8 << 2) + (s8 << 1)) begin
            map.owner = SEG_N;
        end else if (pixel_index < (l8 << 2) + (s8 << 1) + s8) begin
            map.owner = SEG_E;
        end else if (pixel_index < (l8 << 2) + (s8 << 2)) begin
            map.owner = SEG_F;
        end else if (pixel_index < (l8 << 2) + (s8 << 2) + s8) begin
            map.owner = SEG_A;
        end else if (pixel_index < (l8 << 2) + (s8 << 2) + (s8 << 1)) begin
            map.owner = SEG_J;
        end else if (pixel_index < base - s8) begin
            map.owner = SEG_M;
        end else if (pixel_index < base) begin
            map.owner = SEG_D;
        end else if (pixel_index < base + half) begin
            map.owner = SEG_H;
        end else if (pixel_index < base + half + g8) begin
            map.owner = OWNER_GAP;
        end else begin
            map.owner = SEG_G;
        end
    end

endmodule

`default_nettype wire

/* sv/fssd_color_store.sv */
// Segment and gap color registers with command update and owner read.
`default_nettype none

module fssd_color_store #(
    parameter int FONT_ENTRIES = 96
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            exec_en,
    input  fssd_pkg::cmd_t       cmd,
    input  wire logic [3:0]      read_owner,
    output logic      [23:0]     read_color
);
    import fssd_pkg::*;

    logic [23:0] segment_color_reg [SEG_COUNT];
    logic [23:0] segment_color_next [SEG_COUNT];
    logic [23:0] gap_color_reg;
    logic [23:0] gap_color_next;
    logic [6:0]  font_idx;
    logic        char_ok;
    logic [13:0] char_bits;

    assign font_idx  = 7'(cmd.char_code - CHAR_FIRST);
    assign char_ok   = (cmd.char_code >= CHAR_FIRST) && (cmd.char_code <= CHAR_LAST)
                       && ({1'b0, font_idx} < 8'(FONT_ENTRIES));
    assign char_bits = font_lookup(font_idx);

    always_comb begin
        segment_color_next = segment_color_reg;
        gap_color_next     = gap_color_reg;
        unique case (cmd.mode)
            MODE_SET_SEG: begin
                if (cmd.segment_index <= SEG_N) begin
                    segment_color_next[cmd.segment_index] = cmd.color;
                end
            end
            MODE_SET_MASK: begin
                for (int s = 0; s < SEG_COUNT; s++) begin
                    segment_color_next[s] = cmd.segment_bits[s] ? cmd.color : 24'd0;
                end
            end
            MODE_SET_CHAR: begin
                if (char_ok) begin
                    for (int s = 0; s < SEG_COUNT; s++) begin
                        segment_color_next[s] = char_bits[s] ? cmd.color : 24'd0;
                    end
                end
            end
            MODE_ERASE: begin
                for (int s = 0; s < SEG_COUNT; s++) begin
                    segment_color_next[s] = 24'd0;
                end
                gap_color_next = 24'd0;
            end
            MODE_FILL: begin
                for (int s = 0; s < SEG_COUNT; s++) begin
                    segment_color_next[s] = cmd.color;
                end
                gap_color_next = cmd.color;
            end
            MODE_READ: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SEG_COUNT; s++) begin
                segment_color_reg[s] <= 24'd0;
            end
            gap_color_reg <= 24'd0;
        end else if (exec_en) begin
            segment_color_reg <= segment_color_next;
            gap_color_reg     <= gap_color_next;
        end
    end

    always_comb begin
        if (read_owner <= SEG_N) begin
            read_color = segment_color_reg[read_owner];
        end else begin
            read_color = gap_color_reg;
        end
    end

endmodule

`default_nettype wire
